/* src/ssrm_pkg.sv */
package ssrm_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned SLOT_BITS = $clog2(SLOTS);
  localparam int unsigned TICKET_W  = 32;
  localparam int unsigned SIZE_W    = 31;
  localparam int unsigned COUNT_W   = 32;

  localparam logic [SIZE_W-1:0] CAPACITY_RESET = SIZE_W'(4096);

  localparam logic [1:0] CMD_CLAIM   = 2'd0;
  localparam logic [1:0] CMD_COMMIT  = 2'd1;
  localparam logic [1:0] CMD_ACQUIRE = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RETRY    = 2'd1;
  localparam logic [1:0] STAT_BAD_SIZE = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic [TICKET_W-1:0] ticket;
    logic [SIZE_W-1:0]   used_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TICKET_W-1:0] grant_ticket;
    logic [3:0]          slot_index;
    logic [SIZE_W-1:0]   payload_bytes;
    logic [SIZE_W-1:0]   capacity_bytes;
    logic [COUNT_W-1:0]  in_flight;
    logic [COUNT_W-1:0]  committed_count;
    logic [COUNT_W-1:0]  acquired_count;
    logic [COUNT_W-1:0]  released_count;
    logic [COUNT_W-1:0]  full_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

/* src/slot_sequence_ring_manager_core.sv */
// Ring bookkeeping engine for a bounded descriptor queue in which every slot
// carries a sequence word. Each input transaction is one command (claim,
// commit, acquire or release) and yields exactly one result transaction with
// the status, the slot, the granted ticket of a successful claim or acquire,
// the committed size on acquire, the slot capacity, the in-flight count and
// the four wrapping counters. A command is captured; on execute the datapath
// reads the slot's sequence word, compares it and updates the state. The
// result sits in an output register, so the next command is accepted
// while it waits; a command stalls in its execute cycle only while the
// previous result has not been taken. The capacity register may be written
// at any time the engine is idle and takes effect on the next command.
module slot_sequence_ring_manager_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ssrm_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ssrm_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [ssrm_pkg::SIZE_W-1:0] cfg_wdata
);

  ssrm_pkg::ctrl_cmd_t cmd;

  ssrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ssrm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

/* src/ssrm_ctrl.sv */
module ssrm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ssrm_pkg::ctrl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_free;

  assign in_ready    = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state_r == S_EXEC) && out_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.execute) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/ssrm_dpath.sv */
module ssrm_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ssrm_pkg::ctrl_cmd_t                  cmd,
  input  ssrm_pkg::in_item_t                   in_data,
  input  logic                                 cfg_we,
  input  logic [ssrm_pkg::SIZE_W-1:0]          cfg_wdata,
  output ssrm_pkg::out_item_t                  out_data
);

  localparam int unsigned SB = ssrm_pkg::SLOT_BITS;
  localparam int unsigned TW = ssrm_pkg::TICKET_W;
  localparam int unsigned CW = ssrm_pkg::COUNT_W;
  localparam int unsigned SW = ssrm_pkg::SIZE_W;

  ssrm_pkg::in_item_t  item_r;
  ssrm_pkg::out_item_t out_r;
  ssrm_pkg::out_item_t out_nxt;

  logic [SW-1:0] capacity_r;
  logic [TW-1:0] head_r;
  logic [TW-1:0] head_nxt;
  logic [TW-1:0] tail_r;
  logic [TW-1:0] tail_nxt;
  logic [CW-1:0] commit_cnt_r;
  logic [CW-1:0] commit_cnt_nxt;
  logic [CW-1:0] acquire_cnt_r;
  logic [CW-1:0] acquire_cnt_nxt;
  logic [CW-1:0] release_cnt_r;
  logic [CW-1:0] release_cnt_nxt;
  logic [CW-1:0] full_cnt_r;
  logic [CW-1:0] full_cnt_nxt;

  logic [TW-1:0] seq_r [ssrm_pkg::SLOTS];
  logic [SW-1:0] used_r [ssrm_pkg::SLOTS];

  logic [SB-1:0] idx;
  logic [TW-1:0] seq_rd;
  logic [TW-1:0] expect_seq;
  logic          seq_match;
  logic          seq_we;
  logic [TW-1:0] seq_wval;
  logic          used_we;
  logic [TW-1:0] tk_plus1;
  logic [TW-1:0] tail_plus1;

  assign tk_plus1   = item_r.ticket + TW'(1);
  assign tail_plus1 = tail_r + TW'(1);

  always_comb begin
    idx        = item_r.ticket[SB-1:0];
    expect_seq = item_r.ticket;
    case (item_r.command)
      ssrm_pkg::CMD_CLAIM: begin
        idx        = head_r[SB-1:0];
        expect_seq = head_r;
      end
      ssrm_pkg::CMD_COMMIT: begin
        expect_seq = item_r.ticket;
      end
      ssrm_pkg::CMD_ACQUIRE: begin
        idx        = tail_r[SB-1:0];
        expect_seq = tail_plus1;
      end
      ssrm_pkg::CMD_RELEASE: begin
        expect_seq = tk_plus1;
      end
      default: begin
        expect_seq = item_r.ticket;
      end
    endcase
  end

  assign seq_rd    = seq_r[idx];
  assign seq_match = (seq_rd == expect_seq);

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    commit_cnt_nxt  = commit_cnt_r;
    acquire_cnt_nxt = acquire_cnt_r;
    release_cnt_nxt = release_cnt_r;
    full_cnt_nxt    = full_cnt_r;
    seq_we          = 1'b0;
    seq_wval        = tk_plus1;
    used_we         = 1'b0;
    out_nxt         = '0;
    out_nxt.status  = ssrm_pkg::STAT_RETRY;
    case (item_r.command)
      ssrm_pkg::CMD_CLAIM: begin
        if (seq_match) begin
          out_nxt.status       = ssrm_pkg::STAT_OK;
          out_nxt.grant_ticket = head_r;
          head_nxt             = head_r + TW'(1);
        end else begin
          full_cnt_nxt = full_cnt_r + CW'(1);
        end
      end
      ssrm_pkg::CMD_COMMIT: begin
        if ((item_r.used_bytes == '0) || (item_r.used_bytes > capacity_r)) begin
          out_nxt.status = ssrm_pkg::STAT_BAD_SIZE;
        end else if (seq_match) begin
          out_nxt.status = ssrm_pkg::STAT_OK;
          used_we        = 1'b1;
          seq_we         = 1'b1;
          seq_wval       = tk_plus1;
          commit_cnt_nxt = commit_cnt_r + CW'(1);
        end
      end
      ssrm_pkg::CMD_ACQUIRE: begin
        if (seq_match) begin
          out_nxt.status        = ssrm_pkg::STAT_OK;
          out_nxt.grant_ticket  = tail_r;
          out_nxt.payload_bytes = used_r[idx];
          tail_nxt              = tail_plus1;
          acquire_cnt_nxt       = acquire_cnt_r + CW'(1);
        end
      end
      ssrm_pkg::CMD_RELEASE: begin
        if (seq_match) begin
          out_nxt.status  = ssrm_pkg::STAT_OK;
          seq_we          = 1'b1;
          seq_wval        = item_r.ticket + TW'(ssrm_pkg::SLOTS);
          release_cnt_nxt = release_cnt_r + CW'(1);
        end
      end
      default: begin
        out_nxt.status = ssrm_pkg::STAT_RETRY;
      end
    endcase
    out_nxt.slot_index      = 4'(idx);
    out_nxt.capacity_bytes  = capacity_r;
    out_nxt.in_flight       = (commit_cnt_nxt >= acquire_cnt_nxt) ?
                              (commit_cnt_nxt - acquire_cnt_nxt) : '0;
    out_nxt.committed_count = commit_cnt_nxt;
    out_nxt.acquired_count  = acquire_cnt_nxt;
    out_nxt.released_count  = release_cnt_nxt;
    out_nxt.full_count      = full_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.execute) begin
      out_r <= out_nxt;
    end
    if (cmd.execute && used_we) begin
      used_r[idx] <= item_r.used_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r    <= ssrm_pkg::CAPACITY_RESET;
      head_r        <= '0;
      tail_r        <= '0;
      commit_cnt_r  <= '0;
      acquire_cnt_r <= '0;
      release_cnt_r <= '0;
      full_cnt_r    <= '0;
      for (int i = 0; i < ssrm_pkg::SLOTS; i++) begin
        seq_r[i] <= TW'(i);
      end
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (cmd.execute) begin
        head_r        <= head_nxt;
        tail_r        <= tail_nxt;
        commit_cnt_r  <= commit_cnt_nxt;
        acquire_cnt_r <= acquire_cnt_nxt;
        release_cnt_r <= release_cnt_nxt;
        full_cnt_r    <= full_cnt_nxt;
        if (seq_we) begin
          seq_r[idx] <= seq_wval;
        end
      end
    end
  end

  assign out_data = out_r;

endmodule
